// ===== hdl/ihs_pkg.sv =====
// Shared types and constants for the init handshake sequencer.
package ihs_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int MAX_RESULTS = 8;
    localparam int Q_AW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CW        = $clog2(QUEUE_DEPTH + 1);
    localparam int RES_CW      = $clog2(MAX_RESULTS + 1);
    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 24;
    localparam int SHIFT_B1    = 8;
    localparam int SHIFT_B2    = 16;

    typedef logic [BYTE_W-1:0] t_byte;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam logic [1:0] REQ_IN_START = 2'd1;
    localparam logic [1:0] REQ_IN_END   = 2'd2;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_END   = 1'b1;

    localparam logic [1:0] PROG_NOT_STARTED = 2'd0;
    localparam logic [1:0] PROG_STARTED     = 2'd1;
    localparam logic [1:0] PROG_ENDED       = 2'd2;

    localparam t_byte RESP_NONE      = 8'd0;
    localparam t_byte RESP_START_ACC = 8'd1;
    localparam t_byte RESP_START_REJ = 8'd2;
    localparam t_byte RESP_END_ACC   = 8'd3;
    localparam t_byte RESP_END_REJ   = 8'd4;

    localparam t_byte STAT_NONE    = 8'd0;
    localparam t_byte STAT_STARTED = 8'd1;

    localparam t_byte MBX_REQ_NONE  = 8'd0;
    localparam t_byte MBX_REQ_START = 8'd1;
    localparam t_byte MBX_REQ_END   = 8'd2;
    localparam t_byte MBX_CPL_NONE  = 8'd0;
    localparam t_byte MBX_CPL_OK    = 8'd1;

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_READ      = 5'b00010,
        S_EVAL      = 5'b00100,
        S_EMIT_MORE = 5'b01000,
        S_EMIT_LAST = 5'b10000
    } t_ctl_state;

    typedef enum logic [8:0] {
        SEQ_IDLE              = 9'b000000001,
        SEQ_CLEAR_START       = 9'b000000010,
        SEQ_CLEAR_COMPLETE    = 9'b000000100,
        SEQ_REQUEST_START     = 9'b000001000,
        SEQ_REQUEST_END       = 9'b000010000,
        SEQ_SEND_START        = 9'b000100000,
        SEQ_SEND_END          = 9'b001000000,
        SEQ_WAIT_START_REJECT = 9'b010000000,
        SEQ_WAIT_END_REJECT   = 9'b100000000
    } t_seq_state;

    typedef struct packed {
        logic       push;
        logic       push_kind;
        logic       pop;
        logic       b0_we;
        t_byte      b0;
        logic       b1_we;
        t_byte      b1;
        logic       b2_we;
        logic       stored_we;
        logic       stored_val;
        logic       prog_we;
        logic [1:0] prog_val;
        logic       load_out;
        logic       rv;
        logic       rk;
        logic       ra;
        logic       mw;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic       q_full;
        logic       q_empty;
        logic       head_kind;
        logic [1:0] progress;
    } t_status;

endpackage

// ===== hdl/init_handshake_sequencer.sv =====
// Top level of the init handshake sequencer: controller plus datapath.
//
//  channel  direction  handshake                  payload
//  in       sink       i_in_valid / o_in_ready    operation, request_kind, partner word
//  out      source     o_out_valid / i_out_ready  reply, mailbox write and word, last
//
// An enqueue or a non-idle tick is accepted, then gives one result beat.
// An idle tick does a registered queue read, then an evaluate, per popped entry,
// sends any extra result beats, and reads once more when the walk stops on an empty
// queue or the 8-beat limit; at most 8 result beats.
// Reset (synchronous, active low) clears the sequence, progress, pointers and word.
// A stalled result beat holds the block; no new item is taken until it leaves.
module init_handshake_sequencer
    import ihs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_operation,
    input  logic [1:0]        i_request_kind,
    input  logic              i_partner_word_valid,
    input  logic [7:0]        i_partner_response,
    input  logic [7:0]        i_partner_status,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_reply_valid,
    output logic              o_reply_kind,
    output logic              o_reply_accept,
    output logic              o_mailbox_write,
    output logic [WORD_W-1:0] o_mailbox_word,
    output logic              o_last
);

    t_cmd    cmd;
    t_status status;

    ihs_ctrl u_ctrl (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .i_operation          (i_operation),
        .i_request_kind       (i_request_kind),
        .i_partner_word_valid (i_partner_word_valid),
        .i_partner_response   (i_partner_response),
        .i_partner_status     (i_partner_status),
        .i_out_ready          (i_out_ready),
        .i_status             (status),
        .o_in_ready           (o_in_ready),
        .o_out_valid          (o_out_valid),
        .o_cmd                (cmd)
    );

    ihs_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_reply_valid   (o_reply_valid),
        .o_reply_kind    (o_reply_kind),
        .o_reply_accept  (o_reply_accept),
        .o_mailbox_write (o_mailbox_write),
        .o_mailbox_word  (o_mailbox_word),
        .o_last          (o_last)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output beats overlap");

    a_enq_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_operation == OP_ENQUEUE) |=> (o_out_valid && o_last))
        else $error("enqueue did not give a single last beat");

    a_mbx_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_mailbox_write) |-> o_last)
        else $error("mailbox write on a non-final beat");

    a_accept_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_reply_accept) |-> o_reply_valid)
        else $error("accept flag without a reply");

endmodule

// ===== hdl/ihs_dp.sv =====
// Datapath: request queue, mailbox word, progress and the result register.
module ihs_dp
    import ihs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    output logic              o_reply_valid,
    output logic              o_reply_kind,
    output logic              o_reply_accept,
    output logic              o_mailbox_write,
    output logic [WORD_W-1:0] o_mailbox_word,
    output logic              o_last
);

    logic              r_mem [QUEUE_DEPTH];
    logic              r_rd;
    logic [Q_AW-1:0]   r_head;
    logic [Q_AW-1:0]   r_tail;
    logic [Q_CW-1:0]   r_count;
    logic [1:0]        r_prog;
    logic              r_stored;
    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;
    logic              n_stored;

    always_comb begin
        n_stored = i_cmd.stored_we ? i_cmd.stored_val : r_stored;
        n_word   = r_word;
        if (i_cmd.b0_we) begin
            n_word[0 +: BYTE_W] = i_cmd.b0;
        end
        if (i_cmd.b1_we) begin
            n_word[SHIFT_B1 +: BYTE_W] = i_cmd.b1;
        end
        if (i_cmd.b2_we) begin
            n_word[SHIFT_B2 +: BYTE_W] = {{(BYTE_W-1){1'b0}}, n_stored};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_tail] <= i_cmd.push_kind;
        end
        r_rd <= r_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_prog   <= PROG_NOT_STARTED;
            r_stored <= 1'b0;
            r_word   <= '0;
        end else begin
            if (i_cmd.push) begin
                r_tail  <= (r_tail == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + Q_AW'(1);
                r_count <= r_count + Q_CW'(1);
            end else if (i_cmd.pop) begin
                r_head  <= (r_head == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + Q_AW'(1);
                r_count <= r_count - Q_CW'(1);
            end
            if (i_cmd.prog_we) begin
                r_prog <= i_cmd.prog_val;
            end
            r_stored <= n_stored;
            r_word   <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_reply_valid   <= i_cmd.rv;
            o_reply_kind    <= i_cmd.rk;
            o_reply_accept  <= i_cmd.ra;
            o_mailbox_write <= i_cmd.mw;
            o_mailbox_word  <= n_word;
            o_last          <= i_cmd.last;
        end
    end

    assign o_status.q_full    = (r_count == Q_CW'(QUEUE_DEPTH));
    assign o_status.q_empty   = (r_count == '0);
    assign o_status.head_kind = r_rd;
    assign o_status.progress  = r_prog;

endmodule

// ===== hdl/ihs_ctrl.sv =====
// Controller: beat handshakes, queue drain loop and the handshake sequence.
module ihs_ctrl
    import ihs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_operation,
    input  logic [1:0] i_request_kind,
    input  logic       i_partner_word_valid,
    input  t_byte      i_partner_response,
    input  t_byte      i_partner_status,
    input  logic       i_out_ready,
    input  t_status    i_status,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_cmd       o_cmd
);

    t_ctl_state        r_state, n_state;
    t_seq_state        r_seq, n_seq;
    logic [RES_CW-1:0] r_cnt, n_cnt;
    logic              r_pend, n_pend;
    logic              r_pkind, n_pkind;

    always_comb begin
        logic kind_end;
        logic redundant;
        kind_end  = (i_request_kind == REQ_IN_END);
        redundant = (i_status.head_kind == KIND_START && i_status.progress == PROG_STARTED) ||
                    (i_status.head_kind == KIND_END && i_status.progress == PROG_ENDED);
        o_cmd   = '0;
        n_state = r_state;
        n_seq   = r_seq;
        n_cnt   = r_cnt;
        n_pend  = r_pend;
        n_pkind = r_pkind;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_operation == OP_ENQUEUE) begin
                        o_cmd.load_out = 1'b1;
                        o_cmd.last     = 1'b1;
                        if (i_request_kind == REQ_IN_START || i_request_kind == REQ_IN_END) begin
                            if (i_status.q_full) begin
                                o_cmd.rv = 1'b1;
                                o_cmd.rk = kind_end;
                            end else begin
                                o_cmd.push      = 1'b1;
                                o_cmd.push_kind = kind_end;
                            end
                        end
                        n_state = S_EMIT_LAST;
                    end else if (r_seq == SEQ_IDLE) begin
                        n_cnt   = '0;
                        n_pend  = 1'b0;
                        n_state = S_READ;
                    end else begin
                        o_cmd.load_out = 1'b1;
                        o_cmd.last     = 1'b1;
                        n_state        = S_EMIT_LAST;
                        case (r_seq)
                            SEQ_CLEAR_START: begin
                                if (i_partner_word_valid && i_partner_status == STAT_STARTED) begin
                                    o_cmd.b1_we = 1'b1;
                                    o_cmd.b1    = MBX_CPL_OK;
                                    o_cmd.mw    = 1'b1;
                                    n_seq       = SEQ_CLEAR_COMPLETE;
                                end
                            end
                            SEQ_CLEAR_COMPLETE: begin
                                if (i_partner_word_valid && i_partner_status == STAT_NONE) begin
                                    o_cmd.b1_we = 1'b1;
                                    o_cmd.b1    = MBX_CPL_NONE;
                                    o_cmd.mw    = 1'b1;
                                    n_seq       = SEQ_IDLE;
                                end
                            end
                            SEQ_REQUEST_START: begin
                                if (i_partner_word_valid &&
                                    i_partner_response == RESP_START_ACC) begin
                                    o_cmd.stored_we  = 1'b1;
                                    o_cmd.stored_val = 1'b1;
                                    o_cmd.b0_we      = 1'b1;
                                    o_cmd.b0         = MBX_REQ_NONE;
                                    o_cmd.b2_we      = 1'b1;
                                    o_cmd.mw         = 1'b1;
                                    o_cmd.rv         = 1'b1;
                                    o_cmd.rk         = KIND_START;
                                    o_cmd.ra         = 1'b1;
                                    o_cmd.prog_we    = 1'b1;
                                    o_cmd.prog_val   = PROG_STARTED;
                                    n_seq            = SEQ_CLEAR_START;
                                end else if (i_partner_word_valid &&
                                             i_partner_response == RESP_START_REJ) begin
                                    o_cmd.b0_we = 1'b1;
                                    o_cmd.b0    = MBX_REQ_NONE;
                                    o_cmd.mw    = 1'b1;
                                    o_cmd.rv    = 1'b1;
                                    o_cmd.rk    = KIND_START;
                                    n_seq       = SEQ_WAIT_START_REJECT;
                                end
                            end
                            SEQ_REQUEST_END: begin
                                if (i_partner_word_valid &&
                                    i_partner_response == RESP_END_ACC) begin
                                    o_cmd.stored_we  = 1'b1;
                                    o_cmd.stored_val = 1'b0;
                                    o_cmd.b0_we      = 1'b1;
                                    o_cmd.b0         = MBX_REQ_NONE;
                                    o_cmd.b2_we      = 1'b1;
                                    o_cmd.mw         = 1'b1;
                                    o_cmd.rv         = 1'b1;
                                    o_cmd.rk         = KIND_END;
                                    o_cmd.ra         = 1'b1;
                                    o_cmd.prog_we    = 1'b1;
                                    o_cmd.prog_val   = PROG_ENDED;
                                    n_seq            = SEQ_IDLE;
                                end else if (i_partner_word_valid &&
                                             i_partner_response == RESP_END_REJ) begin
                                    o_cmd.b0_we = 1'b1;
                                    o_cmd.b0    = MBX_REQ_NONE;
                                    o_cmd.mw    = 1'b1;
                                    o_cmd.rv    = 1'b1;
                                    o_cmd.rk    = KIND_END;
                                    n_seq       = SEQ_WAIT_END_REJECT;
                                end
                            end
                            SEQ_SEND_START: begin
                                o_cmd.b0_we = 1'b1;
                                o_cmd.b0    = MBX_REQ_START;
                                o_cmd.mw    = 1'b1;
                                n_seq       = SEQ_REQUEST_START;
                            end
                            SEQ_SEND_END: begin
                                o_cmd.b0_we = 1'b1;
                                o_cmd.b0    = MBX_REQ_END;
                                o_cmd.mw    = 1'b1;
                                n_seq       = SEQ_REQUEST_END;
                            end
                            SEQ_WAIT_START_REJECT, SEQ_WAIT_END_REJECT: begin
                                if (i_partner_word_valid && i_partner_response == RESP_NONE) begin
                                    n_seq = SEQ_IDLE;
                                end
                            end
                            default: begin
                                n_seq = SEQ_IDLE;
                            end
                        endcase
                    end
                end
            end
            S_READ: begin
                if (i_status.q_empty || r_cnt == RES_CW'(MAX_RESULTS)) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.last     = 1'b1;
                    o_cmd.rv       = r_pend;
                    o_cmd.rk       = r_pend & r_pkind;
                    o_cmd.ra       = r_pend;
                    n_pend         = 1'b0;
                    n_state        = S_EMIT_LAST;
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.pop = 1'b1;
                if (redundant) begin
                    n_cnt   = r_cnt + RES_CW'(1);
                    n_pend  = 1'b1;
                    n_pkind = i_status.head_kind;
                    if (r_pend) begin
                        o_cmd.load_out = 1'b1;
                        o_cmd.rv       = 1'b1;
                        o_cmd.rk       = r_pkind;
                        o_cmd.ra       = 1'b1;
                        n_state        = S_EMIT_MORE;
                    end else begin
                        n_state = S_READ;
                    end
                end else begin
                    n_seq          = (i_status.head_kind == KIND_END) ? SEQ_SEND_END
                                                                      : SEQ_SEND_START;
                    o_cmd.load_out = 1'b1;
                    o_cmd.last     = 1'b1;
                    o_cmd.rv       = r_pend;
                    o_cmd.rk       = r_pend & r_pkind;
                    o_cmd.ra       = r_pend;
                    n_pend         = 1'b0;
                    n_state        = S_EMIT_LAST;
                end
            end
            S_EMIT_MORE: begin
                if (i_out_ready) begin
                    n_state = S_READ;
                end
            end
            S_EMIT_LAST: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seq   <= SEQ_IDLE;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
            r_pkind <= KIND_START;
        end else begin
            r_state <= n_state;
            r_seq   <= n_seq;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
            r_pkind <= n_pkind;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT_MORE) || (r_state == S_EMIT_LAST);

endmodule

// ===== tb/sv/ihs_reply_checker.sv =====
// Checker for the init handshake sequencer: predicts every result beat and compares it.
module ihs_reply_checker
    import ihs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic              i_operation,
    input  logic [1:0]        i_request_kind,
    input  logic              i_partner_word_valid,
    input  logic [7:0]        i_partner_response,
    input  logic [7:0]        i_partner_status,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic              i_reply_valid,
    input  logic              i_reply_kind,
    input  logic              i_reply_accept,
    input  logic              i_mailbox_write,
    input  logic [WORD_W-1:0] i_mailbox_word,
    input  logic              i_last,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_beats_checked,
    output int                o_replies,
    output int                o_mailbox_writes,
    output t_seq_state        o_seq_phase
);

    typedef struct packed {
        logic              reply_valid;
        logic              reply_kind;
        logic              reply_accept;
        logic              mailbox_write;
        logic [WORD_W-1:0] mailbox_word;
        logic              last;
    } t_reply_beat;

    t_reply_beat       beats_due[$];
    t_reply_beat       want;
    t_seq_state        seq_now;
    logic [1:0]        progress;
    logic              stored_req;
    logic [WORD_W-1:0] out_word;
    logic              q_kinds[QUEUE_DEPTH];
    int                q_head;
    int                q_tail;
    int                q_count;

    assign o_seq_phase = seq_now;

    task automatic expect_beat(input logic rv, input logic rk, input logic ra,
                               input logic mw, input logic lst);
        t_reply_beat b;
        b.reply_valid   = rv;
        b.reply_kind    = rk;
        b.reply_accept  = ra;
        b.mailbox_write = mw;
        b.mailbox_word  = out_word;
        b.last          = lst;
        beats_due.push_back(b);
    endtask

    task automatic step_sequencer(input logic op, input logic [1:0] kind_in,
                                  input logic pv, input t_byte resp, input t_byte stat);
        logic rv;
        logic rk;
        logic ra;
        logic mw;
        logic kind;
        logic redundant_kinds[MAX_RESULTS];
        int   n;
        bit   found;
        rv = 1'b0;
        rk = KIND_START;
        ra = 1'b0;
        mw = 1'b0;
        n = 0;
        found = 1'b0;
        if (op == OP_ENQUEUE) begin
            if (kind_in == REQ_IN_START || kind_in == REQ_IN_END) begin
                kind = (kind_in == REQ_IN_START) ? KIND_START : KIND_END;
                if (q_count >= QUEUE_DEPTH) begin
                    rv = 1'b1;
                    rk = kind;
                end else begin
                    q_kinds[q_tail] = kind;
                    q_tail = (q_tail + 1 >= QUEUE_DEPTH) ? 0 : q_tail + 1;
                    q_count++;
                end
            end
        end else begin
            case (seq_now)
                SEQ_IDLE: begin
                    while (!found && n < MAX_RESULTS && q_count > 0) begin
                        kind = q_kinds[q_head];
                        q_head = (q_head + 1 >= QUEUE_DEPTH) ? 0 : q_head + 1;
                        q_count--;
                        if ((kind == KIND_START && progress == PROG_STARTED) ||
                            (kind == KIND_END && progress == PROG_ENDED)) begin
                            redundant_kinds[n] = kind;
                            n++;
                        end else begin
                            if (kind == KIND_START)
                                seq_now = SEQ_SEND_START;
                            else
                                seq_now = SEQ_SEND_END;
                            found = 1'b1;
                        end
                    end
                end
                SEQ_CLEAR_START: begin
                    if (pv && stat == STAT_STARTED) begin
                        out_word[SHIFT_B1 +: BYTE_W] = MBX_CPL_OK;
                        mw = 1'b1;
                        seq_now = SEQ_CLEAR_COMPLETE;
                    end
                end
                SEQ_CLEAR_COMPLETE: begin
                    if (pv && stat == STAT_NONE) begin
                        out_word[SHIFT_B1 +: BYTE_W] = MBX_CPL_NONE;
                        mw = 1'b1;
                        seq_now = SEQ_IDLE;
                    end
                end
                SEQ_REQUEST_START: begin
                    if (pv && resp == RESP_START_ACC) begin
                        stored_req = 1'b1;
                        out_word[0 +: BYTE_W] = MBX_REQ_NONE;
                        out_word[SHIFT_B2 +: BYTE_W] = {7'd0, stored_req};
                        mw = 1'b1;
                        rv = 1'b1;
                        rk = KIND_START;
                        ra = 1'b1;
                        progress = PROG_STARTED;
                        seq_now = SEQ_CLEAR_START;
                    end else if (pv && resp == RESP_START_REJ) begin
                        out_word[0 +: BYTE_W] = MBX_REQ_NONE;
                        mw = 1'b1;
                        rv = 1'b1;
                        rk = KIND_START;
                        seq_now = SEQ_WAIT_START_REJECT;
                    end
                end
                SEQ_REQUEST_END: begin
                    if (pv && resp == RESP_END_ACC) begin
                        stored_req = 1'b0;
                        out_word[0 +: BYTE_W] = MBX_REQ_NONE;
                        out_word[SHIFT_B2 +: BYTE_W] = {7'd0, stored_req};
                        mw = 1'b1;
                        rv = 1'b1;
                        rk = KIND_END;
                        ra = 1'b1;
                        progress = PROG_ENDED;
                        seq_now = SEQ_IDLE;
                    end else if (pv && resp == RESP_END_REJ) begin
                        out_word[0 +: BYTE_W] = MBX_REQ_NONE;
                        mw = 1'b1;
                        rv = 1'b1;
                        rk = KIND_END;
                        seq_now = SEQ_WAIT_END_REJECT;
                    end
                end
                SEQ_SEND_START: begin
                    out_word[0 +: BYTE_W] = MBX_REQ_START;
                    mw = 1'b1;
                    seq_now = SEQ_REQUEST_START;
                end
                SEQ_SEND_END: begin
                    out_word[0 +: BYTE_W] = MBX_REQ_END;
                    mw = 1'b1;
                    seq_now = SEQ_REQUEST_END;
                end
                SEQ_WAIT_START_REJECT, SEQ_WAIT_END_REJECT: begin
                    if (pv && resp == RESP_NONE)
                        seq_now = SEQ_IDLE;
                end
                default: begin
                    seq_now = SEQ_IDLE;
                end
            endcase
        end
        if (n == 0) begin
            expect_beat(rv, rk, ra, mw, 1'b1);
        end else begin
            for (int i = 0; i < n; i++)
                expect_beat(1'b1, redundant_kinds[i], 1'b1, 1'b0, i == n - 1);
        end
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] exp_val,
                               input logic [WORD_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seq_now = SEQ_IDLE;
            progress = PROG_NOT_STARTED;
            stored_req = 1'b0;
            out_word = '0;
            q_head = 0;
            q_tail = 0;
            q_count = 0;
            beats_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (beats_due.size() == 0) begin
                    $error("result beat with no expectation waiting");
                    o_fail_count++;
                end else begin
                    want = beats_due.pop_front();
                    check_field("reply_valid", WORD_W'(want.reply_valid),
                                WORD_W'(i_reply_valid));
                    check_field("reply_kind", WORD_W'(want.reply_kind),
                                WORD_W'(i_reply_kind));
                    check_field("reply_accept", WORD_W'(want.reply_accept),
                                WORD_W'(i_reply_accept));
                    check_field("mailbox_write", WORD_W'(want.mailbox_write),
                                WORD_W'(i_mailbox_write));
                    check_field("mailbox_word", want.mailbox_word, i_mailbox_word);
                    check_field("last", WORD_W'(want.last), WORD_W'(i_last));
                    o_beats_checked++;
                    if (want.reply_valid)
                        o_replies++;
                    if (want.mailbox_write)
                        o_mailbox_writes++;
                end
            end
            if (i_in_valid && i_in_ready)
                step_sequencer(i_operation, i_request_kind, i_partner_word_valid,
                               i_partner_response, i_partner_status);
        end
        o_pending = beats_due.size();
    end

endmodule

// ===== tb/sv/tb_init_handshake_sequencer.sv =====
// Testbench top for the init handshake sequencer: clock, reset, stimulus and verdict.
module tb_init_handshake_sequencer
    import ihs_pkg::*;
();

    localparam int         STALL_LIMIT   = 2000;
    localparam int         TAIL_CYCLES   = 40;
    localparam int         PHASE_ITEMS   = 46;
    localparam logic [1:0] REQ_IN_NONE   = 2'd0;
    localparam logic [1:0] REQ_IN_SPARE  = 2'd3;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              operation;
    logic [1:0]        request_kind;
    logic              partner_word_valid;
    logic [7:0]        partner_response;
    logic [7:0]        partner_status;
    logic              out_valid;
    logic              out_ready;
    logic              reply_valid;
    logic              reply_kind;
    logic              reply_accept;
    logic              mailbox_write;
    logic [WORD_W-1:0] mailbox_word;
    logic              last;

    int         fail_count;
    int         pending;
    int         beats_checked;
    int         replies;
    int         mailbox_writes;
    t_seq_state seq_phase;

    int tx_idle_pct;
    int rx_idle_pct;
    int stall_cycles;
    int items_sent;
    int ticks_sent;
    int drains;
    int counted;
    bit was_counted;

    init_handshake_sequencer i_dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .o_in_ready           (in_ready),
        .i_operation          (operation),
        .i_request_kind       (request_kind),
        .i_partner_word_valid (partner_word_valid),
        .i_partner_response   (partner_response),
        .i_partner_status     (partner_status),
        .o_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .o_reply_valid        (reply_valid),
        .o_reply_kind         (reply_kind),
        .o_reply_accept       (reply_accept),
        .o_mailbox_write      (mailbox_write),
        .o_mailbox_word       (mailbox_word),
        .o_last               (last)
    );

    ihs_reply_checker i_checker (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .i_in_ready           (in_ready),
        .i_operation          (operation),
        .i_request_kind       (request_kind),
        .i_partner_word_valid (partner_word_valid),
        .i_partner_response   (partner_response),
        .i_partner_status     (partner_status),
        .i_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .i_reply_valid        (reply_valid),
        .i_reply_kind         (reply_kind),
        .i_reply_accept       (reply_accept),
        .i_mailbox_write      (mailbox_write),
        .i_mailbox_word       (mailbox_word),
        .i_last               (last),
        .o_fail_count         (fail_count),
        .o_pending            (pending),
        .o_beats_checked      (beats_checked),
        .o_replies            (replies),
        .o_mailbox_writes     (mailbox_writes),
        .o_seq_phase          (seq_phase)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(negedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic t_byte pick_byte(input int near_max);
        if ($urandom_range(0, 1))
            return t_byte'($urandom_range(0, 255));
        return t_byte'($urandom_range(0, near_max));
    endfunction

    function automatic logic [1:0] pick_kind();
        if ($urandom_range(0, 9) != 0)
            return ($urandom_range(0, 1)) ? REQ_IN_START : REQ_IN_END;
        return ($urandom_range(0, 1)) ? REQ_IN_NONE : REQ_IN_SPARE;
    endfunction

    task automatic send_beat(input logic op, input logic [1:0] kind, input logic pv,
                             input t_byte resp, input t_byte stat);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid           <= 1'b1;
        operation          <= op;
        request_kind       <= kind;
        partner_word_valid <= pv;
        partner_response   <= resp;
        partner_status     <= stat;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        items_sent++;
        if (op == OP_TICK)
            ticks_sent++;
    endtask

    task automatic enqueue(input logic [1:0] kind);
        send_beat(OP_ENQUEUE, kind, 1'($urandom_range(0, 1)), pick_byte(4), pick_byte(1));
    endtask

    task automatic tick(input logic pv, input t_byte resp, input t_byte stat);
        send_beat(OP_TICK, 2'($urandom_range(0, 3)), pv, resp, stat);
    endtask

    task automatic noise_tick();
        tick(1'($urandom_range(0, 1)), pick_byte(4), pick_byte(1));
    endtask

    // hold off until every expected beat has arrived
    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        drains++;
    endtask

    task automatic random_item(output bit counts);
        int         roll;
        logic [1:0] kind;
        roll = $urandom_range(0, 99);
        kind = pick_kind();
        counts = 1'b1;
        if ((seq_phase == SEQ_IDLE && roll < 55) || (seq_phase != SEQ_IDLE && roll < 10)) begin
            enqueue(kind);
            counts = (kind == REQ_IN_START || kind == REQ_IN_END);
        end else if (seq_phase != SEQ_IDLE && roll < 25) begin
            noise_tick();
        end else begin
            case (seq_phase)
                SEQ_CLEAR_START:
                    tick(1'b1, pick_byte(4), STAT_STARTED);
                SEQ_CLEAR_COMPLETE:
                    tick(1'b1, pick_byte(4), STAT_NONE);
                SEQ_REQUEST_START:
                    tick(1'b1, $urandom_range(0, 1) ? RESP_START_ACC : RESP_START_REJ,
                         pick_byte(1));
                SEQ_REQUEST_END:
                    tick(1'b1, $urandom_range(0, 1) ? RESP_END_ACC : RESP_END_REJ,
                         pick_byte(1));
                SEQ_WAIT_START_REJECT, SEQ_WAIT_END_REJECT:
                    tick(1'b1, RESP_NONE, pick_byte(1));
                default:
                    noise_tick();
            endcase
        end
    endtask

    initial begin
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        operation          = OP_ENQUEUE;
        request_kind       = REQ_IN_NONE;
        partner_word_valid = 1'b0;
        partner_response   = RESP_NONE;
        partner_status     = STAT_NONE;
        out_ready          = 1'b0;
        tx_idle_pct        = 6;
        rx_idle_pct        = 85;
        stall_cycles       = 0;
        items_sent         = 0;
        ticks_sent         = 0;
        drains             = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty tick, ignored kinds, then a full start flow with stale and stray words
        tick(1'b0, RESP_NONE, STAT_NONE);
        enqueue(REQ_IN_NONE);
        enqueue(REQ_IN_SPARE);
        enqueue(REQ_IN_START);
        tick(1'b1, RESP_NONE, STAT_NONE);
        tick(1'b1, RESP_NONE, STAT_NONE);
        tick(1'b0, RESP_START_ACC, STAT_STARTED);
        tick(1'b1, 8'hFF, 8'hFF);
        tick(1'b1, RESP_START_ACC, STAT_NONE);
        tick(1'b1, RESP_NONE, STAT_STARTED);
        tick(1'b1, RESP_NONE, STAT_NONE);

        // fill the queue with redundant starts, overflow it, drain in one tick
        repeat (QUEUE_DEPTH) enqueue(REQ_IN_START);
        enqueue(REQ_IN_END);
        tick(1'b1, RESP_NONE, STAT_NONE);

        // end request rejected by the partner
        enqueue(REQ_IN_END);
        tick(1'b1, RESP_NONE, STAT_NONE);
        tick(1'b1, RESP_NONE, STAT_NONE);
        tick(1'b1, RESP_END_REJ, STAT_NONE);
        tick(1'b1, RESP_NONE, STAT_NONE);

        for (int phase = 0; phase < 3; phase++) begin
            drain();
            tx_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 85 : 0;
            rx_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 6 : 0;
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                random_item(was_counted);
                if (was_counted)
                    counted++;
                if ($urandom_range(0, 24) == 0)
                    drain();
            end
        end
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d items (%0d ticks) under three idling mixes, held off %0d times.",
                 items_sent, ticks_sent, drains);
        $display("Checked %0d result beats: %0d replies, %0d mailbox writes.",
                 beats_checked, replies, mailbox_writes);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
